FILE: src/scd_pkg.sv
// Package for the serial code descrambler: constants, register indexes, lookups.
`default_nettype none

package scd_pkg;

    localparam int ROUNDS     = 26;
    localparam int NUM_CHARS  = 8;
    localparam int CHAR_W     = 8;
    localparam int NIB_W      = 4;
    localparam int WORD_W     = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [CHAR_W-1:0] CHAR_FIRST = 8'd65;
    localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'd80;

    localparam logic [REG_IDX_W-1:0] REG_PRODUCT_INDEX  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INITIAL_STATE  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_XOR_KEY_FIRST  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_XOR_KEY_SECOND = 2'd3;

    typedef logic [NIB_W-1:0]  nibble_t;
    typedef logic [WORD_W-1:0] word_t;

    function automatic nibble_t sbox_one(input nibble_t n);
        nibble_t r;
        case (n)
            4'd0:    r = 4'd9;
            4'd1:    r = 4'd3;
            4'd2:    r = 4'd8;
            4'd3:    r = 4'd14;
            4'd4:    r = 4'd11;
            4'd5:    r = 4'd7;
            4'd6:    r = 4'd0;
            4'd7:    r = 4'd12;
            4'd8:    r = 4'd15;
            4'd9:    r = 4'd2;
            4'd10:   r = 4'd13;
            4'd11:   r = 4'd4;
            4'd12:   r = 4'd1;
            4'd13:   r = 4'd6;
            4'd14:   r = 4'd5;
            default: r = 4'd10;
        endcase
        return r;
    endfunction

    function automatic nibble_t sbox_two_inv(input nibble_t n);
        nibble_t r;
        case (n)
            4'd0:    r = 4'd2;
            4'd1:    r = 4'd7;
            4'd2:    r = 4'd10;
            4'd3:    r = 4'd6;
            4'd4:    r = 4'd12;
            4'd5:    r = 4'd9;
            4'd6:    r = 4'd14;
            4'd7:    r = 4'd1;
            4'd8:    r = 4'd3;
            4'd9:    r = 4'd13;
            4'd10:   r = 4'd5;
            4'd11:   r = 4'd15;
            4'd12:   r = 4'd0;
            4'd13:   r = 4'd11;
            4'd14:   r = 4'd8;
            default: r = 4'd4;
        endcase
        return r;
    endfunction

    // rotate right by 7, then reverse all bits: out[i] = in[(38 - i) mod 32]
    function automatic word_t rot_rev(input word_t v);
        word_t r;
        logic [4:0] src;
        for (int i = 0; i < WORD_W; i++) begin
            src  = 5'(38 - i);
            r[i] = v[src];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/serial_code_descrambler_top.sv
// Top level of the serial code descrambler: input register, decode, result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | s_tdata: code_char_0 .. code_char_7
//  m_*     | out       | m_tvalid/m_tready  | m_tdata: serial_value, m_tuser: code_invalid
//  wr_*    | in        | wr_en              | wr_index, wr_data
//
//  Requests pass the input and result registers, one per cycle unless stalled.
//  The permutation of a round is an involution, so all rounds fold into one
//  permutation and one key word of the same depth as a single round.
//  Reset clears the valid flags and the registers to zero.
//  A stalled result holds in the output register; the input register keeps
//  taking requests until both stages are full.
`default_nettype none

module serial_code_descrambler_top #(
    parameter int ROUNDS = scd_pkg::ROUNDS
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      s_tvalid,
    output logic                                           s_tready,
    // code_char_0 [7:0], code_char_1 [15:8], ... code_char_7 [63:56]
    input  wire logic [scd_pkg::NUM_CHARS*scd_pkg::CHAR_W-1:0] s_tdata,
    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    // serial_value [31:0]
    output logic [scd_pkg::WORD_W-1:0]                     m_tdata,
    // code_invalid [0]
    output logic                                           m_tuser,
    input  wire logic                                      wr_en,
    input  wire logic [scd_pkg::REG_IDX_W-1:0]             wr_index,
    input  wire logic [scd_pkg::WORD_W-1:0]                wr_data
);
    import scd_pkg::*;

    localparam bit ODD_ROUNDS = (ROUNDS % 2) == 1;
    localparam bit K_ODD      = (((ROUNDS + 1) / 2) % 2) == 1;
    localparam bit PK_ODD     = ((ROUNDS / 2) % 2) == 1;

    word_t product_index_reg;
    word_t initial_state_reg;
    word_t xor_key_first_reg;
    word_t xor_key_second_reg;

    logic                            in_valid_reg;
    logic [NUM_CHARS*CHAR_W-1:0]     chars_reg;
    logic                            out_valid_reg;
    word_t                           serial_reg;
    logic                            invalid_reg;

    logic    out_free;
    logic    advance;
    logic    bad;
    nibble_t raw [NUM_CHARS];
    nibble_t prev;
    word_t   packed_word;
    word_t   round_key;
    word_t   total_key;
    word_t   serial_next;
    nibble_t seed_prod;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = serial_reg;
    assign m_tuser  = invalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            product_index_reg  <= '0;
            initial_state_reg  <= '0;
            xor_key_first_reg  <= '0;
            xor_key_second_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_PRODUCT_INDEX:  product_index_reg  <= wr_data;
                REG_INITIAL_STATE:  initial_state_reg  <= wr_data;
                REG_XOR_KEY_FIRST:  xor_key_first_reg  <= wr_data;
                REG_XOR_KEY_SECOND: xor_key_second_reg <= wr_data;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        logic [CHAR_W-1:0] c;
        logic [CHAR_W-1:0] diff;
        bad         = 1'b0;
        seed_prod   = initial_state_reg[NIB_W-1:0] * product_index_reg[NIB_W-1:0];
        prev        = seed_prod;
        packed_word = '0;
        for (int i = 0; i < NUM_CHARS; i++)
        begin
            c    = chars_reg[i*CHAR_W +: CHAR_W];
            diff = c - CHAR_FIRST;
            if (c < CHAR_FIRST || c > CHAR_LAST)
            begin
                bad = 1'b1;
            end
            raw[i] = diff[NIB_W-1:0];
        end
        for (int i = 0; i < NUM_CHARS; i++)
        begin
            if (i == 0)
            begin
                packed_word[i*NIB_W +: NIB_W] = sbox_two_inv(raw[i] ^ sbox_one(prev));
            end
            else
            begin
                packed_word[i*NIB_W +: NIB_W] = sbox_two_inv(raw[i] ^ sbox_one(raw[i-1]));
            end
        end
        round_key = rot_rev(xor_key_second_reg) ^ xor_key_first_reg;
        total_key = (K_ODD ? round_key : '0) ^ (PK_ODD ? rot_rev(round_key) : '0);
        serial_next = (ODD_ROUNDS ? rot_rev(packed_word) : packed_word) ^ total_key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chars_reg     <= '0;
            serial_reg    <= '0;
            invalid_reg   <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
                chars_reg    <= s_tdata;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
                serial_reg    <= bad ? '0 : serial_next;
                invalid_reg   <= bad;
            end
        end
    end

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("invalid code with nonzero serial");

    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("advanced request did not reach output");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
`endif

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for the serial code descrambler: directed and random codes and settings.
`timescale 1ns / 1ps

module tb;

    localparam int CODE_W         = scd_pkg::NUM_CHARS * scd_pkg::CHAR_W;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_CODES    = 160;

    // nibble i of each word is the table entry for i
    localparam logic [63:0] FWD_SUBST = 64'hA561_4D2F_C07B_E839;
    localparam logic [63:0] INV_SUBST = 64'h48B0_F5D3_1E9C_6A72;

    typedef struct packed {
        logic [scd_pkg::WORD_W-1:0] serial;
        logic                       bad;
    } serial_out_t;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [CODE_W-1:0]             s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [scd_pkg::WORD_W-1:0]    m_tdata;
    logic                          m_tuser;
    logic                          wr_en    = 1'b0;
    logic [scd_pkg::REG_IDX_W-1:0] wr_index = '0;
    logic [scd_pkg::WORD_W-1:0]    wr_data  = '0;

    logic [scd_pkg::WORD_W-1:0] prod_index = '0;
    logic [scd_pkg::WORD_W-1:0] init_state = '0;
    logic [scd_pkg::WORD_W-1:0] key_first  = '0;
    logic [scd_pkg::WORD_W-1:0] key_second = '0;

    logic [CODE_W-1:0] pending_codes[$];
    serial_out_t       serial_expect_q[$];

    bit          burst       = 1'b0;
    int          stall_token = 0;
    int          stall_seen  = 0;
    int unsigned send_wait   = 0;
    int unsigned rcv_wait    = 0;
    int unsigned hold_cnt    = 0;
    int unsigned idle_cycles = 0;

    int codes_taken    = 0;
    int bad_codes      = 0;
    int serials_seen   = 0;
    int settings_used  = 0;
    int mismatches     = 0;

    serial_code_descrambler_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic serial_out_t predict_serial(input logic [CODE_W-1:0] code);
        serial_out_t                res;
        logic [7:0]                 ch;
        logic [3:0]                 raw_n;
        logic [3:0]                 prev;
        logic [3:0]                 mixed;
        logic [scd_pkg::WORD_W-1:0] word;
        logic [scd_pkg::WORD_W-1:0] rev;
        logic [scd_pkg::WORD_W-1:0] seed_prod;
        int                         fwd_idx;
        int                         inv_idx;
        res = '0;
        for (int i = 0; i < scd_pkg::NUM_CHARS; i++)
        begin
            ch = code[8*i +: 8];
            if (ch < scd_pkg::CHAR_FIRST || ch > scd_pkg::CHAR_LAST)
                res.bad = 1'b1;
        end
        if (!res.bad)
        begin
            seed_prod = init_state * prod_index;
            prev      = seed_prod[3:0];
            word      = '0;
            for (int i = 0; i < scd_pkg::NUM_CHARS; i++)
            begin
                ch      = code[8*i +: 8] - scd_pkg::CHAR_FIRST;
                raw_n   = ch[3:0];
                fwd_idx = 4 * int'(prev);
                mixed   = raw_n ^ FWD_SUBST[fwd_idx +: 4];
                inv_idx = 4 * int'(mixed);
                word[4*i +: 4] = INV_SUBST[inv_idx +: 4];
                prev    = raw_n;
            end
            for (int r = 0; r < scd_pkg::ROUNDS; r++)
            begin
                word = word ^ key_second;
                word = {word[6:0], word[31:7]};
                for (int b = 0; b < scd_pkg::WORD_W; b++)
                    rev[b] = word[scd_pkg::WORD_W-1-b];
                word = rev ^ key_first;
            end
            res.serial = word;
        end
        return res;
    endfunction

    function automatic logic [CODE_W-1:0] uniform_code(input logic [7:0] ch);
        return {scd_pkg::NUM_CHARS{ch}};
    endfunction

    function automatic logic [CODE_W-1:0] random_code(input bit allow_bad);
        logic [CODE_W-1:0] code;
        int                kind;
        int                pos;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < scd_pkg::NUM_CHARS; i++)
            code[8*i +: 8] = scd_pkg::CHAR_FIRST + 8'($urandom_range(0, 15));
        if (allow_bad && kind >= 85)
        begin
            repeat ($urandom_range(1, 3))
            begin
                pos = $urandom_range(0, scd_pkg::NUM_CHARS - 1);
                if (kind < 93)
                    code[8*pos +: 8] = 8'($urandom_range(0, 255));
                else if ($urandom_range(0, 1) == 0)
                    code[8*pos +: 8] = scd_pkg::CHAR_FIRST - 8'd1;
                else
                    code[8*pos +: 8] = scd_pkg::CHAR_LAST + 8'd1;
            end
        end
        return code;
    endfunction

    function automatic logic [scd_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic log_mismatch(input string what, input logic [scd_pkg::WORD_W-1:0] want,
                                input logic [scd_pkg::WORD_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %h, got %h", what, want, got);
    endtask

    task automatic write_reg(input logic [scd_pkg::REG_IDX_W-1:0] idx,
                             input logic [scd_pkg::WORD_W-1:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        case (idx)
            scd_pkg::REG_PRODUCT_INDEX:  prod_index = val;
            scd_pkg::REG_INITIAL_STATE:  init_state = val;
            scd_pkg::REG_XOR_KEY_FIRST:  key_first  = val;
            scd_pkg::REG_XOR_KEY_SECOND: key_second = val;
            default: ;
        endcase
    endtask

    task automatic set_registers(input logic [scd_pkg::WORD_W-1:0] prod,
                                 input logic [scd_pkg::WORD_W-1:0] init,
                                 input logic [scd_pkg::WORD_W-1:0] k_first,
                                 input logic [scd_pkg::WORD_W-1:0] k_second);
        write_reg(scd_pkg::REG_PRODUCT_INDEX, prod);
        write_reg(scd_pkg::REG_INITIAL_STATE, init);
        write_reg(scd_pkg::REG_XOR_KEY_FIRST, k_first);
        write_reg(scd_pkg::REG_XOR_KEY_SECOND, k_second);
        @(posedge clk);
        wr_en <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_codes.size() != 0 || s_tvalid || serial_expect_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // driver
    always @(posedge clk)
    begin
        logic              fire;
        logic              nxt_valid;
        logic [CODE_W-1:0] nxt_data;
        fire      = s_tvalid && s_tready;
        nxt_valid = s_tvalid && !fire;
        nxt_data  = s_tdata;
        if (fire)
            send_wait = burst ? 0 : $urandom_range(0, 3);
        if (rst_n && !nxt_valid)
        begin
            if (send_wait > 0)
                send_wait--;
            else if (pending_codes.size() != 0)
            begin
                nxt_data  = pending_codes.pop_front();
                nxt_valid = 1'b1;
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata  <= nxt_data;
    end

    // monitor
    always @(posedge clk)
    begin
        serial_out_t got;
        serial_out_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.serial = m_tdata;
                got.bad    = m_tuser;
                serials_seen++;
                if (serial_expect_q.size() == 0)
                    log_mismatch("result with none pending", '0, got.serial);
                else
                begin
                    want = serial_expect_q.pop_front();
                    if (got.serial !== want.serial)
                        log_mismatch("serial_value", want.serial, got.serial);
                    if (got.bad !== want.bad)
                        log_mismatch("code_invalid", 32'(want.bad), 32'(got.bad));
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = predict_serial(s_tdata);
                serial_expect_q.push_back(want);
                codes_taken++;
                if (want.bad)
                    bad_codes++;
            end
            if (stall_token != stall_seen)
            begin
                stall_seen = stall_token;
                hold_cnt   = LONG_HOLD;
            end
            if (m_tvalid && m_tready)
                rcv_wait = burst ? 0 : $urandom_range(0, 3);
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else if (rcv_wait > 0)
            begin
                rcv_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [CODE_W-1:0] code;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        pending_codes.push_back(uniform_code(scd_pkg::CHAR_FIRST));
        pending_codes.push_back(uniform_code(scd_pkg::CHAR_LAST));
        pending_codes.push_back({4{scd_pkg::CHAR_FIRST, scd_pkg::CHAR_LAST}});
        pending_codes.push_back(64'h4847_4645_4443_4241);
        pending_codes.push_back(64'h504F_4E4D_4C4B_4A49);
        for (int i = 0; i < scd_pkg::NUM_CHARS; i++)
        begin
            code = uniform_code(scd_pkg::CHAR_FIRST);
            case (i % 4)
                0:       code[8*i +: 8] = scd_pkg::CHAR_FIRST - 8'd1;
                1:       code[8*i +: 8] = scd_pkg::CHAR_LAST + 8'd1;
                2:       code[8*i +: 8] = 8'h00;
                default: code[8*i +: 8] = 8'hFF;
            endcase
            pending_codes.push_back(code);
        end
        pending_codes.push_back(uniform_code(8'h00));
        pending_codes.push_back(uniform_code(8'hFF));
        pending_codes.push_back(random_code(1'b0));
        wait_drained();

        // wrap the seed product past 2^32
        set_registers('1, '1, '1, '1);
        pending_codes.push_back(uniform_code(scd_pkg::CHAR_FIRST));
        pending_codes.push_back(uniform_code(scd_pkg::CHAR_LAST));
        pending_codes.push_back(64'h4847_4645_4443_4241);
        repeat (3) pending_codes.push_back(random_code(1'b0));
        wait_drained();

        set_registers(32'd3, 32'd5, $urandom, '0);
        pending_codes.push_back(uniform_code(scd_pkg::CHAR_LAST));
        repeat (3) pending_codes.push_back(random_code(1'b0));
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_registers(pick_word(), pick_word(), pick_word(), pick_word());
            burst = (p % 4 == 1);
            repeat (PHASE_CODES) pending_codes.push_back(random_code(1'b1));
            if (p == 1 || p == 6)
            begin
                repeat (20) @(negedge clk);
                stall_token++;
            end
            wait_drained();
        end
        burst = 1'b0;
        repeat (8) @(negedge clk);

        $display("Checked %0d results against %0d accepted codes, %0d of them with bad characters.",
                 serials_seen, codes_taken, bad_codes);
        $display("Covered %0d register settings, random gaps on both sides and two long output holds.",
                 settings_used);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/scd_pkg.sv
src/serial_code_descrambler_top.sv
bench/tb.sv
